### hw/rtl/wmh_pkg.sv
// types, constants and mixing functions shared by the word mixing hash
package wmh_pkg;

  localparam int unsigned MixShiftLeft    = 10;
  localparam int unsigned MixShiftRight   = 6;
  localparam int unsigned WhitenShiftA    = 3;
  localparam int unsigned WhitenShiftB    = 11;
  localparam int unsigned WhitenShiftC    = 15;
  localparam int unsigned LaneWidth       = 2;

  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_SHORT = 1'b1;

  localparam logic [LaneWidth:0] ADV_BYTE  = 3'd1;
  localparam logic [LaneWidth:0] ADV_SHORT = 3'd2;

  typedef struct packed {
    logic        first;
    logic [31:0] seed;
    logic [31:0] message_length;
    logic        element_valid;
    logic [15:0] element;
    logic        last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] whitened_value;
  } out_beat_t;

  // item held between the input register and the core
  typedef struct packed {
    logic        first;
    logic [31:0] first_hash;
    logic        element_valid;
    logic [15:0] element;
    logic        last;
  } wmh_item_t;

  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] a;
    logic [31:0] b;
    a = h + w;
    b = a + (a << MixShiftLeft);
    return b ^ (b >> MixShiftRight);
  endfunction

  function automatic logic [31:0] whiten(input logic [31:0] h);
    logic [31:0] a;
    logic [31:0] b;
    a = h + (h << WhitenShiftA);
    b = a ^ (a >> WhitenShiftB);
    return b + (b << WhitenShiftC);
  endfunction

endpackage

### hw/rtl/wmh_in_stage.sv
// input register; mixes seed with length ahead of the core
module wmh_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wmh_pkg::in_beat_t in_data,
  output logic              item_valid,
  input  logic              item_ready,
  output wmh_pkg::wmh_item_t item
);
  import wmh_pkg::*;

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.first         <= in_data.first;
      item.first_hash    <= mix_word(in_data.seed, in_data.message_length);
      item.element_valid <= in_data.element_valid;
      item.element       <= in_data.element;
      item.last          <= in_data.last;
    end
  end

endmodule

### hw/rtl/wmh_core.sv
// running hash state: packs elements into words and mixes full and tail words
module wmh_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               mode_wr_en,
  input  logic               mode_wr_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  wmh_pkg::wmh_item_t item,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [31:0]        res_hash
);
  import wmh_pkg::*;

  logic                 element_mode;
  logic [31:0]          running_hash;
  logic [31:0]          word_buffer;
  logic [LaneWidth-1:0] lane_position;

  logic [31:0]          running_hash_next;
  logic [31:0]          word_buffer_next;
  logic [LaneWidth-1:0] lane_position_next;

  logic [31:0]          h0;
  logic [31:0]          wb0;
  logic [LaneWidth-1:0] lane0;
  logic [31:0]          elem32;
  logic [31:0]          wb1;
  logic [LaneWidth:0]   lane_sum;
  logic [LaneWidth-1:0] lane1;
  logic                 word_full;
  logic                 do_mix;
  logic [31:0]          mixed;
  logic                 fire;

  // a last item needs the result slot; other items pass freely
  assign item_ready = !item.last || !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    h0    = item.first ? item.first_hash : running_hash;
    wb0   = item.first ? 32'd0 : word_buffer;
    lane0 = item.first ? '0 : lane_position;

    if (element_mode == MODE_SHORT) begin
      elem32   = {16'd0, item.element};
      lane_sum = {1'b0, lane0} + ADV_SHORT;
    end else begin
      elem32   = {24'd0, item.element[7:0]};
      lane_sum = {1'b0, lane0} + ADV_BYTE;
    end

    if (item.element_valid) begin
      wb1       = wb0 | (elem32 << {lane0, 3'b000});
      word_full = lane_sum[LaneWidth];
      lane1     = word_full ? '0 : lane_sum[LaneWidth-1:0];
    end else begin
      wb1       = wb0;
      word_full = 1'b0;
      lane1     = lane0;
    end

    // a full word and a padded tail never both occur in one item
    do_mix = word_full || (item.last && (lane1 != '0));
    mixed  = do_mix ? mix_word(h0, wb1) : h0;

    running_hash_next = mixed;
    if (word_full || item.last) begin
      word_buffer_next   = 32'd0;
      lane_position_next = '0;
    end else begin
      word_buffer_next   = wb1;
      lane_position_next = lane1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_mode  <= MODE_BYTE;
      running_hash  <= 32'd0;
      word_buffer   <= 32'd0;
      lane_position <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (mode_wr_en) begin
        element_mode <= mode_wr_data;
      end
      if (fire) begin
        running_hash  <= running_hash_next;
        word_buffer   <= word_buffer_next;
        lane_position <= lane_position_next;
      end
      if (fire && item.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.last) begin
      res_hash <= running_hash_next;
    end
  end

endmodule

### hw/rtl/wmh_out_stage.sv
// whitening finalizer and output register
module wmh_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_ready,
  input  logic [31:0]        res_hash,
  output logic               out_valid,
  input  logic               out_ready,
  output wmh_pkg::out_beat_t out_data
);
  import wmh_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data.hash_value     <= res_hash;
      out_data.whitened_value <= whiten(res_hash);
    end
  end

endmodule

### hw/rtl/word_mixing_one_at_a_time_hash.sv
// One-at-a-time word hash: streams byte or 16-bit elements (per element_mode,
// written through cfg_wr_en/cfg_wr_data; the user must write it only while
// idle, which the block does not enforce), packs them little-endian into
// 32-bit words and mixes each full word; a beat with last set mixes the
// zero-padded tail and returns the raw and whitened hash. One input beat is
// taken every cycle while no last beat waits for the result slot; the rate
// is set by the single mix step that feeds the running hash back in the core
// stage. Results pass the input register, core and whitening output register.
module word_mixing_one_at_a_time_hash (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  wmh_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wmh_pkg::out_beat_t out_data
);
  import wmh_pkg::*;

  wmh_item_t   item;
  logic        item_valid;
  logic        item_ready;
  logic        res_valid;
  logic        res_ready;
  logic [31:0] res_hash;

  wmh_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  wmh_core u_core (
    .clk          (clk),
    .rst          (rst),
    .mode_wr_en   (cfg_wr_en),
    .mode_wr_data (cfg_wr_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_hash     (res_hash)
  );

  wmh_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_hash  (res_hash),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/wmh_checker.sv
// port-level checks for the word mixing hash, bound to the top level
module wmh_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input wmh_pkg::out_beat_t out_data
);
  import wmh_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // whitened field always matches the raw hash it goes with
  a_whiten: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.whitened_value == whiten(out_data.hash_value))
    else $error("whitened value does not match hash value");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // with the output empty nothing can back up to the input
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind word_mixing_one_at_a_time_hash wmh_checker u_wmh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
